### src/bus_map_register_translator_defines.svh
// Assertion macros used by the file that carries concurrent checks.
`ifndef BUS_MAP_REGISTER_TRANSLATOR_DEFINES_SVH
`define BUS_MAP_REGISTER_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BMRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BMRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bmrt_pkg.sv
`timescale 1ns / 1ps

package bmrt_pkg;

   // Table geometry.
   localparam int MAP_ENTRIES = 8192;
   localparam int PAGE_SHIFT  = 9;
   localparam int MAP_IDX_W   = $clog2(MAP_ENTRIES);

   // Field widths.
   localparam int FUNC_W      = 3;
   localparam int INDEX_W     = 14;
   localparam int BOFF_W      = 2;
   localparam int SIZE_W      = 2;
   localparam int DATA_W      = 32;
   localparam int BUS_ADDR_W  = 22;
   localparam int PHYS_W      = 24;
   localparam int MEM_SIZE_W  = 25;
   localparam int PAGE_W      = 15;
   localparam int ENTRY_W     = PAGE_W + 1;
   localparam int BLK_W       = BUS_ADDR_W - PAGE_SHIFT;
   localparam int MA_W        = PAGE_W + PAGE_SHIFT;

   localparam logic [MEM_SIZE_W-1:0] MEM_SIZE_RESET = 25'h100_0000;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_MAP_WRITE       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_MAP_READ        = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TRANSLATE       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_QUIET_TRANSLATE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR_ERROR     = 3'd4;

   // Write size codes.
   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd1;

   // Lane masks for partial writes.
   localparam logic [DATA_W-1:0] BYTE_LANE = 32'h0000_00FF;
   localparam logic [DATA_W-1:0] WORD_LANE = 32'h0000_FFFF;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [INDEX_W-1:0]    map_index;
      logic [BOFF_W-1:0]     byte_offset;
      logic [SIZE_W-1:0]     size_code;
      logic [DATA_W-1:0]     write_data;
      logic [BUS_ADDR_W-1:0] bus_address;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [PHYS_W-1:0] phys_address;
      logic              map_ok;
      logic              nxm_now;
      logic              nxm_sticky;
   } rsp_item_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic commit;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } dp_sts_type;

endpackage

### src/bmrt_req_if.sv
`timescale 1ns / 1ps

interface bmrt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [13:0] map_index;
   logic [1:0]  byte_offset;
   logic [1:0]  size_code;
   logic [31:0] write_data;
   logic [21:0] bus_address;

   modport source (
      output valid, func, map_index, byte_offset, size_code, write_data, bus_address,
      input  ready
   );
   modport sink (
      input  valid, func, map_index, byte_offset, size_code, write_data, bus_address,
      output ready
   );
endinterface

### src/bmrt_rsp_if.sv
`timescale 1ns / 1ps

interface bmrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [23:0] phys_address;
   logic        map_ok;
   logic        nxm_now;
   logic        nxm_sticky;

   modport source (
      output valid, read_data, phys_address, map_ok, nxm_now, nxm_sticky,
      input  ready
   );
   modport sink (
      input  valid, read_data, phys_address, map_ok, nxm_now, nxm_sticky,
      output ready
   );
endinterface

### src/bmrt_ctrl.sv
`timescale 1ns / 1ps

module bmrt_ctrl
   import bmrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;

   // State register; reset starts the table clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs: a transaction is taken only in idle, and it finishes once the
   // output register can take its result.
   always_comb begin
      req_ready    = 1'b0;
      cmd.clear_wr = 1'b0;
      cmd.accept   = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_EXEC: cmd.commit = sts.out_free;
         default: ;
      endcase
   end

endmodule

### src/bmrt_datapath.sv
`timescale 1ns / 1ps

module bmrt_datapath
   import bmrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output dp_sts_type            sts,
   input  req_item_type          req_item,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item,
   input  logic                  csr_write_enable,
   input  logic [MEM_SIZE_W-1:0] csr_write_data
);

   // Map table storage.
   logic [ENTRY_W-1:0] map_mem [MAP_ENTRIES];

   logic [MAP_IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [MEM_SIZE_W-1:0] mem_size_ff;
   logic                  flag_ff, flag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   // Captured transaction.
   logic [FUNC_W-1:0]     func_ff;
   logic [BOFF_W-1:0]     boff_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [DATA_W-1:0]     data_ff;
   logic [PAGE_SHIFT-1:0] off_ff;
   logic [MAP_IDX_W-1:0]  addr_ff;
   logic                  inr_ff;
   logic [ENTRY_W-1:0]    entry_ff;

   // Lookup address and range check for the incoming transaction.
   logic [BLK_W-1:0]     blk;
   logic [31:0]          blk_wide, idx_wide;
   logic [MAP_IDX_W-1:0] look_addr;
   logic                 look_inr;

   always_comb begin
      blk      = req_item.bus_address[BUS_ADDR_W-1:PAGE_SHIFT];
      blk_wide = 32'(blk);
      idx_wide = 32'(req_item.map_index);
      if (req_item.func == FUNC_TRANSLATE || req_item.func == FUNC_QUIET_TRANSLATE) begin
         look_addr = blk_wide[MAP_IDX_W-1:0];
         look_inr  = blk_wide < 32'(MAP_ENTRIES);
      end else begin
         look_addr = idx_wide[MAP_IDX_W-1:0];
         look_inr  = idx_wide < 32'(MAP_ENTRIES);
      end
   end

   // Merge of a partial write into the old entry, seen as a longword.
   logic [DATA_W-1:0]  old_long, lane, mask, new_long;
   logic [4:0]         lane_shift;
   logic [ENTRY_W-1:0] new_entry;
   logic [MA_W-1:0]    ma;
   logic               size_ok, good;

   always_comb begin
      old_long   = {entry_ff[ENTRY_W-1], {(DATA_W-PAGE_W-1){1'b0}}, entry_ff[PAGE_W-1:0]};
      lane       = (size_ff == SIZE_BYTE) ? BYTE_LANE : WORD_LANE;
      lane_shift = {boff_ff, 3'b000};
      mask       = lane << lane_shift;
      if (size_ff == SIZE_BYTE || size_ff == SIZE_WORD) begin
         new_long = ((data_ff & lane) << lane_shift) | (old_long & ~mask);
      end else begin
         new_long = data_ff;
      end
      new_entry = {new_long[DATA_W-1], new_long[PAGE_W-1:0]};
      // The page and the offset in page never overlap, so the sum is a join.
      ma        = {entry_ff[PAGE_W-1:0], off_ff};
      size_ok   = 32'(ma) < 32'(mem_size_ff);
      good      = inr_ff && entry_ff[ENTRY_W-1] &&
                  (func_ff == FUNC_QUIET_TRANSLATE || size_ok);
   end

   // Result and sticky flag for the captured transaction.
   always_comb begin
      flag_in     = flag_ff;
      rsp_item_in = '0;
      unique case (func_ff) inside
         FUNC_MAP_WRITE: begin
            if (inr_ff) begin
               rsp_item_in.map_ok = 1'b1;
            end else begin
               flag_in              = 1'b1;
               rsp_item_in.nxm_now  = 1'b1;
            end
         end
         FUNC_MAP_READ: begin
            if (inr_ff) begin
               rsp_item_in.read_data = old_long;
               rsp_item_in.map_ok    = 1'b1;
            end
         end
         FUNC_TRANSLATE, FUNC_QUIET_TRANSLATE: begin
            if (good) begin
               rsp_item_in.map_ok       = 1'b1;
               rsp_item_in.phys_address = 24'(ma);
            end else if (func_ff == FUNC_TRANSLATE) begin
               flag_in             = 1'b1;
               rsp_item_in.nxm_now = 1'b1;
            end
         end
         FUNC_CLEAR_ERROR: begin
            flag_in            = 1'b0;
            rsp_item_in.map_ok = 1'b1;
         end
         default: ;
      endcase
      rsp_item_in.nxm_sticky = flag_in;
   end

   // Table port: one write (clearing sweep or map write) and one registered read.
   logic                 mem_we;
   logic [MAP_IDX_W-1:0] mem_waddr;
   logic [ENTRY_W-1:0]   mem_wdata;

   always_comb begin
      mem_we    = cmd.clear_wr || (cmd.commit && func_ff == FUNC_MAP_WRITE && inr_ff);
      mem_waddr = cmd.clear_wr ? clr_cnt_ff : addr_ff;
      mem_wdata = cmd.clear_wr ? '0 : new_entry;
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      if (cmd.accept) entry_ff <= map_mem[look_addr];
   end

   // Capture of the accepted transaction.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_item.func;
         boff_ff <= req_item.byte_offset;
         size_ff <= req_item.size_code;
         data_ff <= req_item.write_data;
         off_ff  <= req_item.bus_address[PAGE_SHIFT-1:0];
         addr_ff <= look_addr;
         inr_ff  <= look_inr;
      end
   end

   // Clearing sweep counter.
   assign clr_cnt_in = cmd.clear_wr ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mem_size_ff  <= MEM_SIZE_RESET;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) flag_ff <= flag_in;
         if (csr_write_enable) mem_size_ff <= csr_write_data;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_item_ff <= rsp_item_in;
   end

   assign sts.clear_last = (clr_cnt_ff == MAP_IDX_W'(MAP_ENTRIES - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item       = rsp_item_ff;

endmodule

### src/bus_map_register_translator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Carries
// req_ch    in         valid/ready          func, map_index, byte_offset, size_code,
//                                           write_data, bus_address
// rsp_ch    out        valid/ready          read_data, phys_address, map_ok, nxm_now,
//                                           nxm_sticky
// csr       in         csr_write_enable     csr_write_data (memory size in bytes)
//
// Each transaction has an accept cycle, which reads the map table, and an execute state,
// which merges, writes back and loads the output register once that register is free.
// The single table port (one write, one registered read) sets this split.
// After reset a clearing pass writes all 8192 map entries, one per cycle, during
// which no transaction is accepted; configuration writes are taken throughout.
// A waiting result does not block acceptance; a second result stalls until it is taken.

`include "bus_map_register_translator_defines.svh"

module bus_map_register_translator
   import bmrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bmrt_req_if.sink              req_ch,
   bmrt_rsp_if.source            rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [MEM_SIZE_W-1:0] csr_write_data
);

   ctl_cmd_type  ctl_cmd;
   dp_sts_type   dp_sts;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         rsp_valid;

   // Gather the request payload.
   always_comb begin
      req_item             = '0;
      req_item.func        = req_ch.func;
      req_item.map_index   = req_ch.map_index;
      req_item.byte_offset = req_ch.byte_offset;
      req_item.size_code   = req_ch.size_code;
      req_item.write_data  = req_ch.write_data;
      req_item.bus_address = req_ch.bus_address;
   end

   bmrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   bmrt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctl_cmd),
      .sts              (dp_sts),
      .req_item         (req_item),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Drive the result channel.
   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.read_data    = rsp_item.read_data;
   assign rsp_ch.phys_address = rsp_item.phys_address;
   assign rsp_ch.map_ok       = rsp_item.map_ok;
   assign rsp_ch.nxm_now      = rsp_item.nxm_now;
   assign rsp_ch.nxm_sticky   = rsp_item.nxm_sticky;

   // The clearing pass never overlaps a transaction.
   `BMRT_ASSERT_IMP(a_no_accept_in_clear, clock, reset, ctl_cmd.clear_wr, !req_ch.ready, "transaction accepted during clearing pass")
   // One transaction at a time.
   `BMRT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "second transaction accepted while one is in flight")
   // A finished transaction shows up on the result channel.
   `BMRT_ASSERT_NEXT(a_commit_shows, clock, reset, ctl_cmd.commit, rsp_ch.valid, "committed result not presented")
   // A fresh error is always reflected in the sticky flag, and never with success.
   `BMRT_ASSERT_IMP(a_err_sticky, clock, reset, rsp_ch.valid && rsp_ch.nxm_now, rsp_ch.nxm_sticky && !rsp_ch.map_ok, "error result inconsistent with status")

endmodule
